// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the sigmoid block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is active.
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  `ASSERT_PROP(name, clk, rst_n, !(cond), msg)

`endif

// ===== hw/rtl/sigact_pkg.sv =====
// Package for the sigmoid forward/backward block: widths, item types, sigmoid ROM.
// No dependencies; the ROM contents are computed at elaboration.
package sigact_pkg;

  localparam int unsigned TABLE_ENTRIES   = 256;
  localparam int unsigned INPUT_FRAC_BITS = 12;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned ROM_W  = 17;                       // 65536 means 1.0
  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SPAN_W = INPUT_FRAC_BITS + 3;      // span of 8.0 in input LSBs
  localparam int unsigned MAG_W  = DATA_W + 1;
  localparam int unsigned PROD_W = MAG_W + IDX_W;

  typedef logic [DATA_W-1:0]        q16_t;
  typedef logic signed [DATA_W-1:0] pre_t;
  typedef logic [ROM_W-1:0]         rom_word_t;
  typedef rom_word_t                rom_t [TABLE_ENTRIES + 1];

  typedef struct packed {
    logic cmd;
    pre_t pre_activation;
    q16_t activation;
  } item_t;

  localparam logic CMD_FORWARD  = 1'b0;
  localparam logic CMD_BACKWARD = 1'b1;

  // Shift-subtract unsigned divide, elaboration use only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-8/TABLE_ENTRIES) in Q31, Taylor series with rounding at each term.
  function automatic logic [63:0] exp_step_q31();
    logic [63:0] a;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic [63:0] n;
    a    = udiv64((64'd8 << 31) + (64'(TABLE_ENTRIES) >> 1), 64'(TABLE_ENTRIES));
    pos  = 64'd1 << 31;
    neg  = '0;
    term = 64'd1 << 31;
    for (int k = 1; k <= 30; k++) begin
      n    = 64'(k);
      term = (term * a + (64'd1 << 30)) >> 31;
      term = udiv64(term + (n >> 1), n);
      if (n[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  // Entry k = sigmoid(8k/TABLE_ENTRIES) in Q1.16, 17 bits wide.
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] e;
    logic [63:0] v;
    logic [63:0] d;
    logic [63:0] q;
    e = exp_step_q31();
    v = 64'd1 << 31;
    for (int k = 0; k <= int'(TABLE_ENTRIES); k++) begin
      d      = (64'd1 << 31) + v;
      q      = udiv64((64'd1 << 47) + (d >> 1), d);
      rom[k] = q[ROM_W-1:0];
      v      = (v * e + (64'd1 << 30)) >> 31;
    end
    return rom;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

endpackage

// ===== hw/rtl/sigact_in_if.sv =====
// Input channel of the sigmoid block: valid/ready plus one input item.
// Depends on sigact_pkg.
interface sigact_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  sigact_pkg::pre_t   pre_activation;
  sigact_pkg::q16_t   activation;

  modport source (output valid, cmd, pre_activation, activation, input ready);
  modport sink   (input valid, cmd, pre_activation, activation, output ready);
endinterface

// ===== hw/rtl/sigact_out_if.sv =====
// Output channel of the sigmoid block: valid/ready plus one result item.
// Depends on sigact_pkg.
interface sigact_out_if;
  logic             valid;
  logic             ready;
  sigact_pkg::q16_t result_value;

  modport source (output valid, result_value, input ready);
  modport sink   (input valid, result_value, output ready);
endinterface

// ===== hw/rtl/sigact_core.sv =====
// Combinational datapath: ROM-interpolated sigmoid and A*(1-A) derivative.
// Depends on sigact_pkg (SIG_ROM, widths, item type).
module sigact_core (
  input  sigact_pkg::item_t item_i,
  output sigact_pkg::q16_t  result_value_o
);
  import sigact_pkg::*;

  localparam int unsigned IDXF_W = PROD_W - SPAN_W;
  localparam int unsigned MUL_W  = ROM_W + SPAN_W;

  // forward path
  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] pos_scaled;
  logic [IDXF_W-1:0] idx_full;
  logic [SPAN_W-1:0] frac;
  logic              sat;
  logic [IDX_W-1:0]  idx;
  rom_word_t         lo;
  rom_word_t         hi;
  rom_word_t         diff;
  logic [MUL_W-1:0]  mul;
  logic [MUL_W:0]    mul_rnd;
  logic [ROM_W:0]    sum;
  rom_word_t         s;
  q16_t              fwd;

  // backward path
  logic [MAG_W-1:0]    a_ext;
  logic [2*MAG_W-1:0]  bprod;
  logic [2*MAG_W-1:0]  bprod_rnd;
  q16_t                bwd;

  always_comb begin
    neg = item_i.pre_activation[DATA_W-1];
    mag = neg ? (MAG_W'(1) << DATA_W) - MAG_W'($unsigned(item_i.pre_activation))
              : MAG_W'($unsigned(item_i.pre_activation));

    pos_scaled = PROD_W'(mag) * PROD_W'(TABLE_ENTRIES);
    idx_full   = pos_scaled[PROD_W-1:SPAN_W];
    frac       = pos_scaled[SPAN_W-1:0];
    sat        = idx_full >= IDXF_W'(TABLE_ENTRIES);
    idx        = sat ? '0 : idx_full[IDX_W-1:0];

    lo   = SIG_ROM[idx];
    hi   = SIG_ROM[idx + IDX_W'(1)];
    diff = (hi > lo) ? hi - lo : '0;

    mul     = MUL_W'(diff) * MUL_W'(frac);
    mul_rnd = (MUL_W+1)'(mul) + ((MUL_W+1)'(1) << (SPAN_W - 1));
    sum     = (ROM_W+1)'(lo) + (ROM_W+1)'(mul_rnd >> SPAN_W);

    if (sat || sum > (ROM_W+1)'(1 << DATA_W)) begin
      s = ROM_W'(1 << DATA_W);
    end else begin
      s = sum[ROM_W-1:0];
    end

    if (neg) begin
      fwd = DATA_W'(ROM_W'(1 << DATA_W) - s);
    end else if (s[DATA_W]) begin
      fwd = '1;                          // 1.0 clamps to full scale
    end else begin
      fwd = s[DATA_W-1:0];
    end

    a_ext     = MAG_W'(item_i.activation);
    bprod     = (2*MAG_W)'(a_ext) * (2*MAG_W)'((MAG_W'(1) << DATA_W) - a_ext);
    bprod_rnd = bprod + (2*MAG_W)'(1 << (DATA_W - 1));
    bwd       = bprod_rnd[2*DATA_W-1:DATA_W];   // peak is 0.25, no saturation

    unique case (item_i.cmd)
      CMD_FORWARD:  result_value_o = fwd;
      CMD_BACKWARD: result_value_o = bwd;
      default:      result_value_o = fwd;
    endcase
  end

endmodule

// ===== hw/rtl/sigmoid_activation_fwd_bwd_top.sv =====
// Sigmoid activation, forward (ROM + interpolation) and backward A*(1-A).
// Path: an input transfer loads the input register (stage A), the core computes
// from it, and the result register (stage B) then holds the result for the output.
// Throughput: one item per cycle while the output is not back-pressured.
// Reset: rst_ni async active low clears both valid flags; no other state.
// Depends on sigact_pkg, sigact_in_if, sigact_out_if, sigact_core.
module sigmoid_activation_fwd_bwd_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  sigact_in_if.sink          in_i,
  sigact_out_if.source       out_o
);
  import sigact_pkg::*;

  // Two-register pipeline:
  //   stage A holds the accepted item,
  //   stage B holds the finished result toward the output channel.
  // Each stage refills whenever it is empty or its content leaves in the
  // same cycle, so a waiting result does not stop new input transfers
  // as long as stage A can still take one.
  logic  a_valid_q, a_valid_d;
  item_t a_item_q;
  logic  b_valid_q, b_valid_d;
  q16_t  b_result_q;
  q16_t  core_result;

  logic  b_free;   // stage B can load this cycle
  logic  a_free;   // stage A can load this cycle
  logic  in_xfer;

  assign b_free  = !b_valid_q || out_o.ready;
  assign a_free  = !a_valid_q || b_free;
  assign in_xfer = in_i.valid && a_free;

  assign in_i.ready         = a_free;
  assign out_o.valid        = b_valid_q;
  assign out_o.result_value = b_result_q;

  // All arithmetic for an item happens between stage A and stage B.
  sigact_core u_core (
    .item_i         (a_item_q),
    .result_value_o (core_result)
  );

  always_comb begin
    a_valid_d = a_valid_q;
    b_valid_d = b_valid_q;
    if (b_free) begin
      b_valid_d = a_valid_q;   // A moves into B (or B drains empty)
    end
    if (a_free) begin
      a_valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_item_q.cmd            <= in_i.cmd;
      a_item_q.pre_activation <= in_i.pre_activation;
      a_item_q.activation     <= in_i.activation;
    end
    if (b_free && a_valid_q) begin
      b_result_q <= core_result;
    end
  end

endmodule

// ===== hw/rtl/sigact_checker.sv =====
// Port-level checker for the sigmoid block, bound to the top level.
// Depends on assert_macros.svh, sigact_pkg and sigmoid_activation_fwd_bwd_top.
`include "assert_macros.svh"

module sigact_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input sigact_pkg::q16_t result_value_i
);
  import sigact_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // an accepted item must show up as a valid result on the output
  `ASSERT_PROP(a_item_reaches_out, clk_i, rst_ni, in_xfer |-> ##2 out_valid_i, "item lost in pipe")
  // input side stalls only because the output is back-pressured
  `ASSERT_PROP(a_stall_cause, clk_i, rst_ni, !in_ready_i |-> (out_valid_i && !out_ready_i), "bad stall")
  // nothing comes out right after reset
  `ASSERT_PROP(a_clean_reset, clk_i, rst_ni, $rose(rst_ni) |-> !out_valid_i, "result after reset")
  // a held result keeps its value
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(result_value_i)), "held result changed")

endmodule

bind sigmoid_activation_fwd_bwd_top sigact_checker u_sigact_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_value_i (out_o.result_value)
);
